>>> hw/rtl/voa_pkg.sv
// Shared types, constants and functions of the vector octant angle core.
// No dependencies; imported by every module of the core.
package voa_pkg;

	localparam int unsigned CompW = 16;
	localparam int unsigned FracW = 8;
	localparam int unsigned RemW  = CompW + 1;
	localparam int unsigned OctW  = 3;
	localparam int unsigned AngW  = 11;
	localparam int unsigned NumCells = FracW;

	localparam logic [FracW-1:0] FracOne = 8'd128;
	localparam logic [AngW-1:0]  AngZero = 11'h7FF;

	typedef struct packed {
		logic             zero;
		logic [OctW-1:0]  oct;
		logic [RemW-1:0]  rem;
		logic [CompW-1:0] dvs;
		logic [FracW-1:0] quo;
	} stage_t;

	function automatic logic [OctW-1:0] octant_of(input logic [2:0] idx);
		logic [OctW-1:0] oct;
		case (idx)
			3'd0: oct = 3'd1;
			3'd1: oct = 3'd0;
			3'd2: oct = 3'd2;
			3'd3: oct = 3'd3;
			3'd4: oct = 3'd6;
			3'd5: oct = 3'd7;
			3'd6: oct = 3'd5;
			3'd7: oct = 3'd4;
			default: oct = 3'd0;
		endcase
		return oct;
	endfunction

endpackage

>>> hw/rtl/voa_fold.sv
// Input stage: folds the vector into the first octant and registers it.
// Depends on voa_pkg.
module voa_fold (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         vec_x,
	input  logic [15:0]         vec_y,
	output logic                out_valid,
	input  logic                out_ready,
	output voa_pkg::stage_t     out_data
);
	import voa_pkg::*;

	logic [CompW-1:0] ax, ay;
	logic             xneg, yneg, swap;
	stage_t           fold;
	logic             vld_q;
	stage_t           data_q;

	always_comb begin
		ax = vec_x[15] ? (~vec_x + 16'd1) : vec_x;
		ay = vec_y[15] ? (~vec_y + 16'd1) : vec_y;
		xneg = vec_x[15] || (vec_x == '0);
		yneg = vec_y[15] || (vec_y == '0);
		swap = ax < ay;
		fold.zero = (ax == '0) && (ay == '0);
		fold.oct = octant_of({xneg, yneg, swap});
		fold.rem = {1'b0, (swap ? ax : ay)};
		fold.dvs = swap ? ay : ax;
		fold.quo = '0;
	end

	assign in_ready = !vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= fold;
		end
	end

	assign out_valid = vld_q;
	assign out_data  = data_q;

endmodule

>>> hw/rtl/voa_div_cell.sv
// One restoring-division cell: settles one fraction bit and passes the item on.
// Depends on voa_pkg.
module voa_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  voa_pkg::stage_t     in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output voa_pkg::stage_t     out_data
);
	import voa_pkg::*;

	logic             ge;
	logic [RemW-1:0]  diff;
	stage_t           nxt;
	logic             vld_q;
	stage_t           data_q;

	always_comb begin
		ge   = in_data.rem >= {1'b0, in_data.dvs};
		diff = ge ? (in_data.rem - {1'b0, in_data.dvs}) : in_data.rem;
		nxt      = in_data;
		nxt.rem  = {diff[CompW-1:0], 1'b0};
		nxt.quo  = {in_data.quo[FracW-2:0], ge};
	end

	assign in_ready = !vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = vld_q;
	assign out_data  = data_q;

endmodule

>>> hw/rtl/voa_out.sv
// Output stage: mirrors the fraction in odd octants, adds the octant base and holds the result.
// Depends on voa_pkg.
module voa_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  voa_pkg::stage_t     in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [10:0]         angle
);
	import voa_pkg::*;

	logic [FracW-1:0] frac;
	logic [9:0]       sum;
	logic [AngW-1:0]  ang;
	logic             vld_q;
	logic [AngW-1:0]  angle_q;

	always_comb begin
		frac = in_data.oct[0] ? (FracOne - in_data.quo) : in_data.quo;
		sum  = {in_data.oct, 7'd0} + {2'd0, frac};
		ang  = in_data.zero ? AngZero : {1'b0, sum};
	end

	assign in_ready = !vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			angle_q <= ang;
		end
	end

	assign out_valid = vld_q;
	assign angle     = angle_q;

endmodule

>>> hw/rtl/vector_octant_angle_core.sv
// Vector octant angle core: fold stage, eight division cells, output stage.
// An accepted input item passes the fold, division-cell and output registers in order to m_tdata.
// Throughput is one item per cycle while the output side does not stall.
// Every stage holds its item while the next one is full and stalled, so stalls ripple back.
// Reset (arst_n low) empties all stages at once; payload registers are not reset.
// Depends on voa_pkg, voa_fold, voa_div_cell and voa_out.
module vector_octant_angle_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // vec_x [15:0], vec_y [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // angle [10:0], zero padding [15:11]
);
	import voa_pkg::*;

	logic                valid_c [NumCells+1];
	logic                ready_c [NumCells+1];
	stage_t              data_c  [NumCells+1];
	logic [AngW-1:0]     angle;

	voa_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.vec_x     (s_tdata[15:0]),
		.vec_y     (s_tdata[31:16]),
		.out_valid (valid_c[0]),
		.out_ready (ready_c[0]),
		.out_data  (data_c[0])
	);

	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		voa_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_data   (data_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_data  (data_c[i+1])
		);
	end

	voa_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_c[NumCells]),
		.in_ready  (ready_c[NumCells]),
		.in_data   (data_c[NumCells]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.angle     (angle)
	);

	assign m_tdata = {5'd0, angle};

endmodule

>>> hw/rtl/voa_chk.sv
// Port-level checker for the vector octant angle core, bound to its top level.
// Depends on vector_octant_angle_core.
module voa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("Result item shown during reset.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Stalled result item changed.");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("Input stalled while the output side is ready.");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:11] == 5'd0 && (!m_tdata[10] || m_tdata[10:0] == 11'h7FF))
		else $error("Angle out of range.");

endmodule

bind vector_octant_angle_core voa_chk u_voa_chk (.*);

>>> tb/vector_octant_angle_core_tb.sv
// Self-checking testbench for vector_octant_angle_core: it streams vectors in and
// compares each angle against a predictor, under random idling and a long output stall.
// Depends only on the core RTL and voa_pkg.
module vector_octant_angle_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [10:0] NO_ANGLE = 11'h7FF;
	localparam logic [23:0] OCTANT_BY_FOLD = {3'd4, 3'd5, 3'd7, 3'd6, 3'd3, 3'd2, 3'd0, 3'd1};
	localparam int unsigned STALL_LIMIT = 1000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // vec_x [15:0], vec_y [31:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // angle [10:0], zero [15:11]

	logic [10:0] expected_angles[$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned hold_off_cycles = 0;
	bit          src_idle_on = 1'b1;
	bit          rcv_idle_on = 1'b1;

	vector_octant_angle_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [10:0] predict_angle(input logic signed [15:0] vx,
			input logic signed [15:0] vy);
		int ax;
		int ay;
		int frac;
		logic [2:0] fold;
		logic [2:0] oct;
		ax = (vx <= 0) ? -int'(vx) : int'(vx);
		ay = (vy <= 0) ? -int'(vy) : int'(vy);
		if (ax == 0 && ay == 0)
			return NO_ANGLE;
		fold = {vx <= 0, vy <= 0, 1'b0};
		if (ax >= ay) begin
			frac = (ay * 128) / ax;
		end else begin
			fold[0] = 1'b1;
			frac = (ax * 128) / ay;
		end
		oct = OCTANT_BY_FOLD[fold*3 +: 3];
		if (oct[0])
			frac = 128 - frac;
		return 11'((int'(oct) * 128 + frac) & 1023);
	endfunction

	task automatic send_vector(input logic [15:0] vx, input logic [15:0] vy);
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {vy, vx};
		do @(posedge clk); while (!s_tready);
		expected_angles.push_back(predict_angle(vx, vy));
	endtask

	function automatic logic [15:0] random_near(input logic [15:0] base);
		return base + 16'($urandom_range(0, 6)) - 16'd3;
	endfunction

	task automatic test_directed;
		send_vector(16'sd0, 16'sd0);
		send_vector(16'sd32767, 16'sd0);
		send_vector(-16'sd32768, 16'sd0);
		send_vector(16'sd0, 16'sd32767);
		send_vector(16'sd0, -16'sd32768);
		send_vector(-16'sd32768, -16'sd32768);
		send_vector(16'sd32767, 16'sd32767);
		send_vector(16'sd32767, -16'sd32768);
		send_vector(-16'sd32768, 16'sd32767);
		send_vector(16'sd1, 16'sd0);
		send_vector(16'sd0, 16'sd1);
		send_vector(-16'sd1, 16'sd0);
		send_vector(16'sd0, -16'sd1);
		send_vector(16'sd1, 16'sd1);
		send_vector(-16'sd1, -16'sd1);
		send_vector(16'sd300, 16'sd200);
		send_vector(16'sd32767, 16'sd32766);
		send_vector(16'sd100, 16'sd3000);
		send_vector(16'sd1000, -16'sd999);
		send_vector(16'sd1, -16'sd32768);
		send_vector(-16'sd32768, 16'sd1);
		send_vector(-16'sd5, 16'sd300);
		send_vector(-16'sd1, -16'sd7);
	endtask

	task automatic test_random_full_range(input int unsigned count);
		logic [31:0] word;
		repeat (count) begin
			word = $urandom;
			send_vector(word[15:0], word[31:16]);
		end
	endtask

	task automatic test_random_corner_regions(input int unsigned count);
		logic [15:0] vx;
		logic [15:0] vy;
		repeat (count) begin
			case ($urandom_range(0, 3))
				0: begin
					vx = 16'($urandom_range(0, 16)) - 16'd8;
					vy = 16'($urandom_range(0, 16)) - 16'd8;
				end
				1: begin
					vx = 16'($urandom);
					vy = $urandom_range(0, 1) ? random_near(vx) : -random_near(vx);
				end
				2: begin
					vx = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom);
					vy = (vx == 16'h0000) ? 16'($urandom) : 16'h0000;
				end
				default: begin
					vx = $urandom_range(0, 1) ? 16'h8000 : random_near(16'h8000);
					vy = 16'($urandom);
				end
			endcase
			send_vector(vx, vy);
		end
	endtask

	task automatic test_output_hold_off(input int unsigned count);
		src_idle_on = 1'b0;
		hold_off_cycles = 80;
		test_random_full_range(count);
		src_idle_on = 1'b1;
	endtask

	task automatic test_streaming_no_gaps(input int unsigned count);
		src_idle_on = 1'b0;
		rcv_idle_on = 1'b0;
		test_random_full_range(count / 2);
		test_random_corner_regions(count / 2);
	endtask

	initial begin
		int unsigned stall_len;
		m_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold_off_cycles != 0) begin
				stall_len = hold_off_cycles;
				hold_off_cycles = 0;
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
				m_tready <= 1'b1;
			end else if (rcv_idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_angles.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected item, angle %0d", $time, $signed(m_tdata[10:0]));
			end else if (m_tdata !== {5'd0, expected_angles[0]}) begin
				mismatch_count++;
				$display("%0t: angle mismatch, expected %0d (0x%04h), actual %0d (0x%04h)",
					$time, $signed(expected_angles[0]), {5'd0, expected_angles[0]},
					$signed(m_tdata[10:0]), m_tdata);
				void'(expected_angles.pop_front());
			end else begin
				void'(expected_angles.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_full_range(600);
		test_random_corner_regions(400);
		test_output_hold_off(60);
		test_streaming_no_gaps(500);
		s_tvalid <= 1'b0;
		while (expected_angles.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
